[rtl/core/vtrs_pkg.sv]
package vtrs_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TrigW  = 16;
  localparam int unsigned ZoomW  = 24;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned WideW  = 48;

  localparam logic [CfgW-1:0] TurnReset = 32'h4000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHIFT_X = 3'd0,
    REG_SHIFT_Y = 3'd1,
    REG_SHIFT_Z = 3'd2,
    REG_TURN_X  = 3'd3,
    REG_TURN_Y  = 3'd4,
    REG_TURN_Z  = 3'd5,
    REG_ZOOM    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] in_z;
  } vtx_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     clipped;
  } vtx_out_t;

  // coordinates in flight between stages
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     clip;
  } vtx_t;

  // rotating pair p, q plus the untouched coordinate w
  typedef struct packed {
    logic signed [CoordW-1:0] p;
    logic signed [CoordW-1:0] q;
    logic signed [CoordW-1:0] w;
    logic                     clip;
  } rot_t;

  typedef struct packed {
    logic                     clip;
    logic signed [CoordW-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [WideW-1:0] v);
    sat_t r;
    if (v > 48'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = 32'sh7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = -32'sh8000_0000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/vertex_translate_rotate_scale_unit.sv]
// channel  ports                          direction  accepted when
// input    start, busy, in_data           in         start && !busy
// result   out_valid, out_data            out        out_valid (one cycle, no hold-off)
// config   cfg_we, cfg_index, cfg_data    in         cfg_we
//
// one vertex per cycle, the result registered through the stages
// (translate, two stages per rotation about x, y, z, two for the scale multiply)
// busy is always low: the pipeline never stalls since results cannot be held off
// synchronous active-low reset clears the valid bits and loads the register defaults
module vertex_translate_rotate_scale_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  vtrs_pkg::vtx_in_t                   in_data,
  output logic                                out_valid,
  output vtrs_pkg::vtx_out_t                  out_data,
  input  logic                                cfg_we,
  input  logic [vtrs_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [vtrs_pkg::CfgW-1:0]           cfg_data
);
  import vtrs_pkg::*;

  logic signed [CoordW-1:0] shift_x_r, shift_y_r, shift_z_r;
  logic [CfgW-1:0]          turn_x_r, turn_y_r, turn_z_r;
  logic [ZoomW-1:0]         zoom_r;

  sat_t                     tx, ty, tz;
  vtx_t                     xl_nxt;
  vtx_t                     xl_r;
  logic                     xl_vld_r;

  rot_t                     rx_in, rx_out;
  rot_t                     ry_in, ry_out;
  rot_t                     rz_in, rz_out;
  logic                     rx_vld, ry_vld, rz_vld;
  vtx_t                     sc_in;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
      turn_x_r  <= TurnReset;
      turn_y_r  <= TurnReset;
      turn_z_r  <= TurnReset;
      zoom_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHIFT_X: shift_x_r <= cfg_data;
        REG_SHIFT_Y: shift_y_r <= cfg_data;
        REG_SHIFT_Z: shift_z_r <= cfg_data;
        REG_TURN_X:  turn_x_r  <= cfg_data;
        REG_TURN_Y:  turn_y_r  <= cfg_data;
        REG_TURN_Z:  turn_z_r  <= cfg_data;
        REG_ZOOM:    zoom_r    <= cfg_data[ZoomW-1:0];
        default: begin
        end
      endcase
    end
  end

  // translate
  always_comb begin
    tx = sat32(WideW'(in_data.in_x) + WideW'(shift_x_r));
    ty = sat32(WideW'(in_data.in_y) + WideW'(shift_y_r));
    tz = sat32(WideW'(in_data.in_z) + WideW'(shift_z_r));
    xl_nxt.x    = tx.val;
    xl_nxt.y    = ty.val;
    xl_nxt.z    = tz.val;
    xl_nxt.clip = tx.clip | ty.clip | tz.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xl_vld_r <= 1'b0;
    end else begin
      xl_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    xl_r <= xl_nxt;
  end

  // about x: pair (y, z)
  always_comb begin
    rx_in.p    = xl_r.y;
    rx_in.q    = xl_r.z;
    rx_in.w    = xl_r.x;
    rx_in.clip = xl_r.clip;
  end

  vtrs_rot u_rot_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (xl_vld_r),
    .in_data  (rx_in),
    .turn     (turn_x_r),
    .out_vld  (rx_vld),
    .out_data (rx_out)
  );

  // about y: pair (z, x)
  always_comb begin
    ry_in.p    = rx_out.q;
    ry_in.q    = rx_out.w;
    ry_in.w    = rx_out.p;
    ry_in.clip = rx_out.clip;
  end

  vtrs_rot u_rot_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rx_vld),
    .in_data  (ry_in),
    .turn     (turn_y_r),
    .out_vld  (ry_vld),
    .out_data (ry_out)
  );

  // about z: pair (x, y)
  always_comb begin
    rz_in.p    = ry_out.q;
    rz_in.q    = ry_out.w;
    rz_in.w    = ry_out.p;
    rz_in.clip = ry_out.clip;
  end

  vtrs_rot u_rot_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (ry_vld),
    .in_data  (rz_in),
    .turn     (turn_z_r),
    .out_vld  (rz_vld),
    .out_data (rz_out)
  );

  always_comb begin
    sc_in.x    = rz_out.p;
    sc_in.y    = rz_out.q;
    sc_in.z    = rz_out.w;
    sc_in.clip = rz_out.clip;
  end

  vtrs_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (rz_vld),
    .in_data  (sc_in),
    .zoom     (zoom_r),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

  assign busy = 1'b0;

endmodule

[rtl/core/vtrs_rot.sv]
module vtrs_rot (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  vtrs_pkg::rot_t                   in_data,
  input  logic [vtrs_pkg::CfgW-1:0]        turn,
  output logic                             out_vld,
  output vtrs_pkg::rot_t                   out_data
);
  import vtrs_pkg::*;

  logic signed [TrigW-1:0] cos_v;
  logic signed [TrigW-1:0] sin_v;

  logic                    vld_a_r;
  logic signed [47:0]      pc_r, qs_r, ps_r, qc_r;
  logic signed [CoordW-1:0] w_a_r;
  logic                    clip_a_r;

  logic signed [48:0]      sum_p;
  logic signed [48:0]      sum_q;
  sat_t                    sat_p;
  sat_t                    sat_q;
  rot_t                    out_nxt;
  rot_t                    out_r;
  logic                    out_vld_r;

  assign cos_v = turn[CfgW-1:TrigW];
  assign sin_v = turn[TrigW-1:0];

  // products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pc_r     <= in_data.p * cos_v;
    qs_r     <= in_data.q * sin_v;
    ps_r     <= in_data.p * sin_v;
    qc_r     <= in_data.q * cos_v;
    w_a_r    <= in_data.w;
    clip_a_r <= in_data.clip;
  end

  // sum, round half up, saturate
  always_comb begin
    sum_p = 49'(pc_r) - 49'(qs_r) + 49'sd8192;
    sum_q = 49'(ps_r) + 49'(qc_r) + 49'sd8192;
    sat_p = sat32(WideW'($signed(sum_p[48:14])));
    sat_q = sat32(WideW'($signed(sum_q[48:14])));
    out_nxt.p    = sat_p.val;
    out_nxt.q    = sat_q.val;
    out_nxt.w    = w_a_r;
    out_nxt.clip = clip_a_r | sat_p.clip | sat_q.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

endmodule

[rtl/core/vtrs_scale.sv]
module vtrs_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  vtrs_pkg::vtx_t                   in_data,
  input  logic [vtrs_pkg::ZoomW-1:0]       zoom,
  output logic                             out_vld,
  output vtrs_pkg::vtx_out_t               out_data
);
  import vtrs_pkg::*;

  logic signed [ZoomW:0]   k;

  logic                    vld_a_r;
  logic signed [56:0]      px_r, py_r, pz_r;
  logic                    bypass_r;
  vtx_t                    pass_r;

  logic signed [56:0]      rx, ry, rz;
  sat_t                    sx, sy, sz;
  vtx_out_t                out_nxt;
  vtx_out_t                out_r;
  logic                    out_vld_r;

  assign k = $signed({1'b0, zoom});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    px_r     <= in_data.x * k;
    py_r     <= in_data.y * k;
    pz_r     <= in_data.z * k;
    bypass_r <= (zoom == '0);
    pass_r   <= in_data;
  end

  always_comb begin
    rx = px_r + 57'sd32768;
    ry = py_r + 57'sd32768;
    rz = pz_r + 57'sd32768;
    sx = sat32(WideW'($signed(rx[56:16])));
    sy = sat32(WideW'($signed(ry[56:16])));
    sz = sat32(WideW'($signed(rz[56:16])));
    if (bypass_r) begin
      out_nxt.out_x   = pass_r.x;
      out_nxt.out_y   = pass_r.y;
      out_nxt.out_z   = pass_r.z;
      out_nxt.clipped = pass_r.clip;
    end else begin
      out_nxt.out_x   = sx.val;
      out_nxt.out_y   = sy.val;
      out_nxt.out_z   = sz.val;
      out_nxt.clipped = pass_r.clip | sx.clip | sy.clip | sz.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

endmodule

[sim/vtrs_checker.sv]
module vtrs_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  vtrs_pkg::vtx_in_t            in_data,
  input  logic                         out_valid,
  input  vtrs_pkg::vtx_out_t           out_data,
  input  logic                         cfg_we,
  input  logic [vtrs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [vtrs_pkg::CfgW-1:0]    cfg_data,
  output int unsigned                  fail_count,
  output int unsigned                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vtrs_pkg::*;

  localparam int unsigned ReportLimit = 10;

  logic signed [CoordW-1:0] shift_x, shift_y, shift_z;
  logic [CfgW-1:0]          turn_x, turn_y, turn_z;
  logic [ZoomW-1:0]         zoom;
  bit                       saturated;
  int unsigned              reported;
  vtx_out_t                 expected_vertices[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      saturated = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      saturated = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // round half up, then saturate
  function automatic longint round_clamp(input longint v, input int n);
    return clamp32((v + (longint'(1) << (n - 1))) >>> n);
  endfunction

  function automatic vtx_out_t transform_vertex(input vtx_in_t v);
    longint px, py, pz, c, s, a, b, k;
    vtx_out_t r;
    saturated = 1'b0;
    px = clamp32(longint'($signed(v.in_x)) + longint'(shift_x));
    py = clamp32(longint'($signed(v.in_y)) + longint'(shift_y));
    pz = clamp32(longint'($signed(v.in_z)) + longint'(shift_z));
    c = longint'($signed(turn_x[31:16]));
    s = longint'($signed(turn_x[15:0]));
    a = round_clamp(py * c - pz * s, 14);
    b = round_clamp(py * s + pz * c, 14);
    py = a;
    pz = b;
    c = longint'($signed(turn_y[31:16]));
    s = longint'($signed(turn_y[15:0]));
    a = round_clamp(px * c + pz * s, 14);
    b = round_clamp(pz * c - px * s, 14);
    px = a;
    pz = b;
    c = longint'($signed(turn_z[31:16]));
    s = longint'($signed(turn_z[15:0]));
    a = round_clamp(px * c - py * s, 14);
    b = round_clamp(px * s + py * c, 14);
    px = a;
    py = b;
    if (zoom != '0) begin
      k  = longint'({40'd0, zoom});
      px = round_clamp(px * k, 16);
      py = round_clamp(py * k, 16);
      pz = round_clamp(pz * k, 16);
    end
    r.out_x   = px[31:0];
    r.out_y   = py[31:0];
    r.out_z   = pz[31:0];
    r.clipped = saturated;
    return r;
  endfunction

  always @(posedge clk) begin
    vtx_out_t want;
    if (!rst_n) begin
      shift_x = '0;
      shift_y = '0;
      shift_z = '0;
      turn_x  = TurnReset;
      turn_y  = TurnReset;
      turn_z  = TurnReset;
      zoom    = '0;
    end else begin
      if (out_valid) begin
        if (expected_vertices.size() == 0) begin
          fail_count++;
          if (reported < ReportLimit) begin
            reported++;
            $display("unexpected transaction: x=%h y=%h z=%h clipped=%b",
                     out_data.out_x, out_data.out_y, out_data.out_z, out_data.clipped);
          end
        end else begin
          want = expected_vertices.pop_front();
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.out_z !== want.out_z || out_data.clipped !== want.clipped) begin
            fail_count++;
            if (reported < ReportLimit) begin
              reported++;
              $display({"mismatch: expected x=%h y=%h z=%h clipped=%b, ",
                        "got x=%h y=%h z=%h clipped=%b"},
                       want.out_x, want.out_y, want.out_z, want.clipped,
                       out_data.out_x, out_data.out_y, out_data.out_z, out_data.clipped);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SHIFT_X: shift_x = cfg_data;
          REG_SHIFT_Y: shift_y = cfg_data;
          REG_SHIFT_Z: shift_z = cfg_data;
          REG_TURN_X:  turn_x  = cfg_data;
          REG_TURN_Y:  turn_y  = cfg_data;
          REG_TURN_Z:  turn_z  = cfg_data;
          REG_ZOOM:    zoom    = cfg_data[ZoomW-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_vertices.push_back(transform_vertex(in_data));
      end
    end
    pending = expected_vertices.size();
  end

endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vtrs_pkg::*;

  localparam int unsigned LatencyPause = 12;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 115;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  vtx_in_t             in_data;
  logic                out_valid;
  vtx_out_t            out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         cycle_count = 0;

  always #5 clk = ~clk;

  vertex_translate_rotate_scale_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vtrs_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("vertex_translate_rotate_scale_unit verification failed");
      $finish;
    end
  end

  function automatic vtx_in_t vertex(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z);
    vtx_in_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    return v;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      4:       return $urandom_range(32'h0400_0000) - 32'h0200_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_shift();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  // cosine in the upper half, sine in the lower half
  function automatic logic [31:0] pick_turn();
    case ($urandom_range(8))
      0:       return TurnReset;
      1:       return 32'h0000_4000;
      2:       return 32'h2d41_2d41;
      3:       return 32'hd2bf_2d41;
      4:       return 32'h7fff_8000;
      5:       return 32'h8000_7fff;
      6:       return 32'hc000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_zoom();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'h0001_0000;
      2:       return 32'h00ff_ffff;
      3:       return $urandom_range(32'h0002_0000, 1);
      default: return $urandom;
    endcase
  endfunction

  // each cycle is idle with the given percentage
  task automatic send_vertex(input vtx_in_t v, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= v;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LatencyPause) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] sz, input logic [31:0] tx,
                               input logic [31:0] ty, input logic [31:0] tz,
                               input logic [31:0] zm);
    start <= 1'b0;
    drain();
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
    write_reg(REG_TURN_X, tx);
    write_reg(REG_TURN_Y, ty);
    write_reg(REG_TURN_Z, tz);
    write_reg(REG_ZOOM, zm);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned idle_pct;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SHIFT_X;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: identity transform, no scaling
    send_vertex(vertex(32'h0, 32'h0, 32'h0), 0);
    send_vertex(vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0);
    send_vertex(vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
    send_vertex(vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001), 0);
    send_vertex(vertex(32'h0001_8000, 32'hfffe_8000, 32'h0001_0000), 0);

    // non-unit pairs, translation overflow, largest scale
    load_settings(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                  32'h7fff_7fff, 32'h8000_8000, 32'h8000_7fff, 32'h00ff_ffff);
    send_vertex(vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0), 0);
    send_vertex(vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff), 0);
    send_vertex(vertex(32'h0000_0001, 32'h0000_0001, 32'h0000_0001), 0);
    send_vertex(vertex(32'h0, 32'h0, 32'h0), 0);
    send_vertex(vertex(32'hffff_ffff, 32'h0000_0002, 32'hffff_fffe), 0);

    // quarter turn about z, unit scale with junk above the zoom field
    load_settings(32'h0, 32'h0, 32'h0, TurnReset, TurnReset, 32'h0000_4000, 32'hab01_0000);
    send_vertex(vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000), 0);
    send_vertex(vertex(32'h8000_0000, 32'h8000_0000, 32'h0), 0);
    send_vertex(vertex(32'h0000_2001, 32'hffff_e000, 32'h7fff_ffff), 0);
    send_vertex(vertex(32'h7fff_ffff, 32'h0, 32'h8000_0000), 0);

    // smallest nonzero scale, half rounding up
    load_settings(32'h0000_8000, 32'hffff_8000, 32'h0, TurnReset, TurnReset, TurnReset,
                  32'h0000_0001);
    send_vertex(vertex(32'h0, 32'h0, 32'h0000_8000), 0);
    send_vertex(vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_8000), 0);
    send_vertex(vertex(32'h0000_7fff, 32'h0000_8001, 32'hffff_7fff), 0);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p % 4)
        1:       idle_pct = 57;
        3:       idle_pct = 15;
        default: idle_pct = 0;
      endcase
      if (p == 3) begin
        load_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_7fff,
                      32'h7fff_7fff, 32'h7fff_7fff, 32'h00ff_ffff);
      end else if (p == 6) begin
        load_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_8000,
                      32'h8000_8000, 32'h8000_8000, 32'h0000_0001);
      end else begin
        load_settings(pick_shift(), pick_shift(), pick_shift(), pick_turn(), pick_turn(),
                      pick_turn(), pick_zoom());
      end
      for (int i = 0; i < PhaseItems; i++) begin
        send_vertex(vertex(pick_coord(), pick_coord(), pick_coord()), idle_pct);
      end
    end

    start <= 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("vertex_translate_rotate_scale_unit verification clean");
    end else begin
      $display("vertex_translate_rotate_scale_unit verification failed");
    end
    $finish;
  end

endmodule
